[src/sfd_pkg.sv]
// Shared types, constants and saturation helpers for the stereo feedback delay.
package sfd_pkg;

   localparam int DELAY_DEPTH_DEF = 131072;
   localparam int SAMPLE_BITS_DEF = 24;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 17;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DELAY,
      CSR_FEEDBACK,
      CSR_WIDTH,
      CSR_PING_PONG,
      CSR_LEFT_WET,
      CSR_RIGHT_WET,
      CSR_HIGHPASS,
      CSR_LOWPASS
   } csr_index_type;

   localparam logic [16:0] UNITY_Q16      = 17'd65536;
   localparam logic [15:0] POINT_NINE_Q16 = 16'd58982;
   localparam logic [15:0] LOWPASS_RESET  = 16'hFFFF;

   typedef struct packed {
      logic mul;
      logic hp;
      logic lpm;
      logic lp;
   } sfd_lane_ctl_type;

   function automatic logic [16:0] clamp_gain(input logic [16:0] g);
      return (g > UNITY_Q16) ? UNITY_Q16 : g;
   endfunction

   function automatic logic signed [39:0] sat_to(input logic signed [39:0] x, input int bits);
      logic signed [39:0] hi;
      logic signed [39:0] lo;
      hi = (40'sd1 <<< (bits - 1)) - 40'sd1;
      lo = -hi - 40'sd1;
      priority if (x > hi) begin
         return hi;
      end else if (x < lo) begin
         return lo;
      end else begin
         return x;
      end
   endfunction

endpackage

[src/sfd_lane.sv]
// One channel lane: feedback scaling, highpass, lowpass and wet mix with the dry sample.
module sfd_lane
   import sfd_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sfd_lane_ctl_type              ctl,
   input  logic signed [SAMPLE_BITS:0]   mix_in,
   input  logic signed [SAMPLE_BITS-1:0] dry_in,
   input  logic [31:0]                   fb_scale,
   input  logic [15:0]                   hp_coef,
   input  logic [15:0]                   lp_coef,
   input  logic [16:0]                   wet_gain,
   output logic signed [SAMPLE_BITS:0]   fbk_out,
   output logic signed [SAMPLE_BITS-1:0] wet_out
);

   localparam int MW = SAMPLE_BITS + 1;
   localparam logic signed [MW+32:0] FB_HALF = {{(MW+1){1'b0}}, 1'b1, 31'd0};

   logic signed [MW+32:0] fbk_prod;
   logic signed [MW+32:0] fbk_rnd;
   logic signed [MW-1:0]  fbk_in;
   logic signed [MW-1:0]  fbk_ff;

   logic signed [35:0] hpd;
   logic signed [52:0] hpp;
   logic signed [52:0] hpr;
   logic signed [35:0] hpv_in;
   logic signed [35:0] hpv_ff;
   logic signed [39:0] hp_y_sat;
   logic signed [31:0] hp_y;
   logic signed [39:0] hps_sat;
   logic signed [31:0] hps_in;
   logic signed [31:0] hps_ff;
   logic signed [39:0] hpo_sat;
   logic signed [31:0] hpo_in;
   logic signed [31:0] hpo_ff;

   logic signed [35:0] lpd;
   logic signed [52:0] lpp;
   logic signed [52:0] lpr;
   logic signed [35:0] lpv_in;
   logic signed [35:0] lpv_ff;
   logic signed [39:0] lp_y_sat;
   logic signed [31:0] lpy_in;
   logic signed [31:0] lpy_ff;
   logic signed [39:0] lps_sat;
   logic signed [31:0] lps_in;
   logic signed [31:0] lps_ff;

   logic signed [49:0] wprod;
   logic signed [49:0] wrnd;
   logic signed [33:0] wet_term;
   logic signed [39:0] out_sat;

   always_comb begin
      fbk_prod = mix_in * $signed({1'b0, fb_scale});
      fbk_rnd  = fbk_prod + FB_HALF;
      fbk_in   = fbk_rnd[MW+31:32];

      hpd    = 36'(mix_in) - 36'(hps_ff);
      hpp    = hpd * $signed({1'b0, hp_coef});
      hpr    = hpp + 53'sd32768;
      hpv_in = hpr[51:16];

      hp_y_sat = sat_to(40'(hpv_ff) + 40'(hps_ff), 32);
      hp_y     = hp_y_sat[31:0];
      hps_sat  = sat_to(40'(hp_y) + 40'(hpv_ff), 32);
      hps_in   = hps_sat[31:0];
      hpo_sat  = sat_to(40'(mix_in) - 40'(hp_y), 32);
      hpo_in   = hpo_sat[31:0];

      lpd    = 36'(hpo_ff) - 36'(lps_ff);
      lpp    = lpd * $signed({1'b0, lp_coef});
      lpr    = lpp + 53'sd32768;
      lpv_in = lpr[51:16];

      lp_y_sat = sat_to(40'(lpv_ff) + 40'(lps_ff), 32);
      lpy_in   = lp_y_sat[31:0];
      lps_sat  = sat_to(40'(lpy_in) + 40'(lpv_ff), 32);
      lps_in   = lps_sat[31:0];

      wprod    = lpy_ff * $signed({1'b0, wet_gain});
      wrnd     = wprod + 50'sd32768;
      wet_term = wrnd[49:16];
      out_sat  = sat_to(40'(dry_in) + 40'(wet_term), SAMPLE_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hps_ff <= '0;
         lps_ff <= '0;
      end else begin
         if (ctl.hp) begin
            hps_ff <= hps_in;
         end
         if (ctl.lp) begin
            lps_ff <= lps_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mul) begin
         fbk_ff <= fbk_in;
         hpv_ff <= hpv_in;
      end
      if (ctl.hp) begin
         hpo_ff <= hpo_in;
      end
      if (ctl.lpm) begin
         lpv_ff <= lpv_in;
      end
      if (ctl.lp) begin
         lpy_ff <= lpy_in;
      end
   end

   assign fbk_out = fbk_ff;
   assign wet_out = out_sat[SAMPLE_BITS-1:0];

endmodule

[src/stereo_feedback_delay.sv]
// Stereo ping-pong feedback delay: delay memories, cross-mix, sequencer and two channel lanes.
//
//   Channel  Ports                                   Direction  Carries
//   req      req_valid/ready, req_left_in/right_in   in         one stereo sample pair
//   rsp      rsp_valid/ready, rsp_left_out/right_out out        one processed stereo pair
//   csr      csr_valid/ready, csr_index, csr_data    in         one register write
//
// After acceptance an item passes the mix step, the multiply, highpass, lowpass-multiply and
// lowpass steps of the lanes and the wet step, where its result goes into the output register.
// A new item is accepted in the cycle after the previous one has been loaded into the output
// register, so the block takes no new item before it is through with the last one.
// The delay memories read as zero until written; a wrap flag tracks the fill, so no
// clearing pass follows reset. Reset is synchronous and active high.
// A result not taken holds the lanes in their final step; the csr port never stalls.
module stereo_feedback_delay
   import sfd_pkg::*;
#(
   parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_left_in,
   input  logic signed [SAMPLE_BITS-1:0] req_right_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0] rsp_right_out,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_data
);

   localparam int WPW = $clog2(DELAY_DEPTH);
   localparam int AW  = ((WPW > 17) ? WPW : 17) + 2;
   localparam int MW  = SAMPLE_BITS + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MIX,
      ST_MUL,
      ST_HP,
      ST_LPM,
      ST_LP,
      ST_WET
   } state_type;

   state_type state_ff;

   logic [16:0] delay_ff;
   logic [16:0] feedback_ff;
   logic [16:0] width_ff;
   logic        ping_pong_ff;
   logic [16:0] left_wet_ff;
   logic [16:0] right_wet_ff;
   logic [15:0] highpass_ff;
   logic [15:0] lowpass_ff;

   logic [32:0] fb_prod;
   logic [31:0] fb_ff;

   logic [WPW-1:0] wp_ff;
   logic           wrap_ff;
   logic           rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_l_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_r_ff;

   logic req_accept;
   logic out_free;
   logic mem_we;

   logic [AW-1:0]  d_ext;
   logic [AW-1:0]  d_cl;
   logic [AW-1:0]  rp_sum;
   logic [AW-1:0]  rp_wrap;
   logic [WPW-1:0] rd_addr;
   logic           rd_ok;
   logic           rd_ok_ff;

   logic signed [SAMPLE_BITS-1:0] mem_l [DELAY_DEPTH];
   logic signed [SAMPLE_BITS-1:0] mem_r [DELAY_DEPTH];
   logic signed [SAMPLE_BITS-1:0] dout_l_ff;
   logic signed [SAMPLE_BITS-1:0] dout_r_ff;

   logic signed [SAMPLE_BITS-1:0] xl_ff;
   logic signed [SAMPLE_BITS-1:0] xr_ff;

   logic signed [SAMPLE_BITS-1:0]  dl;
   logic signed [SAMPLE_BITS-1:0]  dr;
   logic [16:0]                    opp;
   logic signed [SAMPLE_BITS+17:0] cross_l_prod;
   logic signed [SAMPLE_BITS+17:0] cross_r_prod;
   logic signed [SAMPLE_BITS+17:0] cross_l_rnd;
   logic signed [SAMPLE_BITS+17:0] cross_r_rnd;
   logic signed [MW:0]             avg_sum;
   logic signed [MW-1:0]           ml_in;
   logic signed [MW-1:0]           mr_in;
   logic signed [MW-1:0]           ml_ff;
   logic signed [MW-1:0]           mr_ff;

   logic signed [MW-1:0]          fl;
   logic signed [MW-1:0]          fr;
   logic signed [39:0]            wr_l_sat;
   logic signed [39:0]            wr_r_sat;
   logic signed [SAMPLE_BITS-1:0] wr_l;
   logic signed [SAMPLE_BITS-1:0] wr_r;
   logic signed [SAMPLE_BITS-1:0] wet_l;
   logic signed [SAMPLE_BITS-1:0] wet_r;

   sfd_lane_ctl_type lane_ctl;

   assign csr_ready  = 1'b1;
   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign mem_we     = (state_ff == ST_HP);

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff     <= '0;
         feedback_ff  <= '0;
         width_ff     <= '0;
         ping_pong_ff <= 1'b0;
         left_wet_ff  <= '0;
         right_wet_ff <= '0;
         highpass_ff  <= '0;
         lowpass_ff   <= LOWPASS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_DELAY:     delay_ff     <= csr_data;
            CSR_FEEDBACK:  feedback_ff  <= csr_data;
            CSR_WIDTH:     width_ff     <= csr_data;
            CSR_PING_PONG: ping_pong_ff <= csr_data[0];
            CSR_LEFT_WET:  left_wet_ff  <= csr_data;
            CSR_RIGHT_WET: right_wet_ff <= csr_data;
            CSR_HIGHPASS:  highpass_ff  <= csr_data[15:0];
            CSR_LOWPASS:   lowpass_ff   <= csr_data[15:0];
            default:       delay_ff     <= delay_ff;
         endcase
      end
   end

   // The feedback scale depends on configuration alone, so it is kept in a register.
   assign fb_prod = clamp_gain(feedback_ff) * POINT_NINE_Q16;

   always_ff @(posedge clock) begin
      fb_ff <= fb_prod[31:0];
   end

   always_comb begin
      d_ext   = AW'(delay_ff);
      d_cl    = (d_ext > AW'(DELAY_DEPTH - 1)) ? AW'(DELAY_DEPTH - 1) : d_ext;
      rp_sum  = AW'(wp_ff) + AW'(DELAY_DEPTH) - d_cl;
      rp_wrap = (rp_sum >= AW'(DELAY_DEPTH)) ? (rp_sum - AW'(DELAY_DEPTH)) : rp_sum;
      rd_addr = rp_wrap[WPW-1:0];
      rd_ok   = wrap_ff || (rd_addr < wp_ff);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_l[wp_ff] <= wr_l;
      end
      if (req_accept) begin
         dout_l_ff <= mem_l[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_r[wp_ff] <= wr_r;
      end
      if (req_accept) begin
         dout_r_ff <= mem_r[rd_addr];
      end
   end

   always_comb begin
      dl           = rd_ok_ff ? dout_l_ff : '0;
      dr           = rd_ok_ff ? dout_r_ff : '0;
      opp          = UNITY_Q16 - clamp_gain(width_ff);
      cross_l_prod = dr * $signed({1'b0, opp});
      cross_r_prod = dl * $signed({1'b0, opp});
      cross_l_rnd  = cross_l_prod + (SAMPLE_BITS+18)'(65536);
      cross_r_rnd  = cross_r_prod + (SAMPLE_BITS+18)'(65536);
      avg_sum      = (MW+1)'(dl) + (MW+1)'(dr) + (MW+1)'(1);
      if (width_ff != '0) begin
         ml_in = MW'(dl) + MW'(cross_l_rnd[SAMPLE_BITS+17:17]);
         mr_in = MW'(dr) + MW'(cross_r_rnd[SAMPLE_BITS+17:17]);
      end else begin
         ml_in = avg_sum[MW:1];
         mr_in = avg_sum[MW:1];
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         xl_ff    <= req_left_in;
         xr_ff    <= req_right_in;
         rd_ok_ff <= rd_ok;
      end
      if (state_ff == ST_MIX) begin
         ml_ff <= ml_in;
         mr_ff <= mr_in;
      end
   end

   always_comb begin
      if (ping_pong_ff) begin
         wr_l_sat = sat_to(40'(fr), SAMPLE_BITS);
         wr_r_sat = sat_to(40'(xr_ff) + 40'(fl), SAMPLE_BITS);
      end else begin
         wr_l_sat = sat_to(40'(xl_ff) + 40'(fl), SAMPLE_BITS);
         wr_r_sat = sat_to(40'(xr_ff) + 40'(fr), SAMPLE_BITS);
      end
      wr_l = wr_l_sat[SAMPLE_BITS-1:0];
      wr_r = wr_r_sat[SAMPLE_BITS-1:0];
   end

   always_comb begin
      lane_ctl.mul = (state_ff == ST_MUL);
      lane_ctl.hp  = (state_ff == ST_HP);
      lane_ctl.lpm = (state_ff == ST_LPM);
      lane_ctl.lp  = (state_ff == ST_LP);
   end

   sfd_lane #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_lane_l (
      .clock    (clock),
      .reset    (reset),
      .ctl      (lane_ctl),
      .mix_in   (ml_ff),
      .dry_in   (xl_ff),
      .fb_scale (fb_ff),
      .hp_coef  (highpass_ff),
      .lp_coef  (lowpass_ff),
      .wet_gain (clamp_gain(left_wet_ff)),
      .fbk_out  (fl),
      .wet_out  (wet_l)
   );

   sfd_lane #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_lane_r (
      .clock    (clock),
      .reset    (reset),
      .ctl      (lane_ctl),
      .mix_in   (mr_ff),
      .dry_in   (xr_ff),
      .fb_scale (fb_ff),
      .hp_coef  (highpass_ff),
      .lp_coef  (lowpass_ff),
      .wet_gain (clamp_gain(right_wet_ff)),
      .fbk_out  (fr),
      .wet_out  (wet_r)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         wrap_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_WET && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  state_ff <= ST_MIX;
               end
            end
            ST_MIX: state_ff <= ST_MUL;
            ST_MUL: state_ff <= ST_HP;
            ST_HP: begin
               if (wp_ff == WPW'(DELAY_DEPTH - 1)) begin
                  wp_ff   <= '0;
                  wrap_ff <= 1'b1;
               end else begin
                  wp_ff <= wp_ff + WPW'(1);
               end
               state_ff <= ST_LPM;
            end
            ST_LPM: state_ff <= ST_LP;
            ST_LP:  state_ff <= ST_WET;
            ST_WET: begin
               if (out_free) begin
                  rsp_l_ff <= wet_l;
                  rsp_r_ff <= wet_r;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_l_ff;
   assign rsp_right_out = rsp_r_ff;

   a_accept_starts_mix: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_MIX))
      else $error("An accepted item did not move the sequencer to the mix step.");

   a_wp_moves_on_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_HP) |=> $stable(wp_ff))
      else $error("The write pointer moved outside the memory write step.");

   a_result_from_wet: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_WET))
      else $error("A result appeared without passing the final lane step.");

   a_idle_after_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WET && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("A finished item was not loaded into the output register.");

endmodule

[verif/tb.sv]
// Self-checking testbench for stereo_feedback_delay, with a bit-exact echo predictor.
`timescale 1ns / 100ps

module tb;
   import sfd_pkg::*;

   localparam int SBITS = SAMPLE_BITS_DEF;
   localparam int DEPTH = DELAY_DEPTH_DEF;
   localparam longint Q16_ONE = 65536;
   localparam longint FEEDBACK_SCALE = 58982;
   localparam int STALL_LIMIT = 2000;
   localparam logic [CSR_DATA_BITS-1:0] LONGEST_DELAY = CSR_DATA_BITS'(DEPTH - 1);

   typedef struct packed {
      logic signed [SBITS-1:0] left;
      logic signed [SBITS-1:0] right;
   } stereo_pair_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic signed [SBITS-1:0] req_left_in;
   logic signed [SBITS-1:0] req_right_in;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [SBITS-1:0] rsp_left_out;
   logic signed [SBITS-1:0] rsp_right_out;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0] csr_data;

   int unsigned sender_idle_pct;
   int unsigned receiver_idle_pct;
   int mismatches = 0;
   int quiet_cycles = 0;

   stereo_pair_type expected_pairs[$];

   bit signed [SBITS-1:0] left_line [DEPTH];
   bit signed [SBITS-1:0] right_line [DEPTH];
   int unsigned line_head;
   longint highpass_mem [2];
   longint lowpass_mem [2];

   logic [16:0] cfg_delay = '0;
   logic [16:0] cfg_feedback = '0;
   logic [16:0] cfg_width = '0;
   logic        cfg_ping_pong = 1'b0;
   logic [16:0] cfg_left_wet = '0;
   logic [16:0] cfg_right_wet = '0;
   logic [15:0] cfg_highpass = '0;
   logic [15:0] cfg_lowpass = 16'hFFFF;

   stereo_feedback_delay dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_left_in  (req_left_in),
      .req_right_in (req_right_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_left_out (rsp_left_out),
      .rsp_right_out(rsp_right_out),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint round_shift(input longint x, input int n);
      return (x + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic longint saturate(input longint x, input int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) << (bits - 1)) - 1;
      lo = -hi - 1;
      if (x > hi) begin
         return hi;
      end else if (x < lo) begin
         return lo;
      end
      return x;
   endfunction

   function automatic longint limit_gain(input logic [16:0] g);
      return (longint'(g) > Q16_ONE) ? Q16_ONE : longint'(g);
   endfunction

   task automatic filter_step(inout longint s, input longint x, input longint g,
                              input bit high, output longint y_out);
      longint v;
      longint y;
      v = round_shift(g * (x - s), 16);
      y = saturate(v + s, 32);
      s = saturate(y + v, 32);
      y_out = high ? saturate(x - y, 32) : y;
   endtask

   task automatic predict_echo_mix(input logic signed [SBITS-1:0] l_in,
                                   input logic signed [SBITS-1:0] r_in,
                                   output stereo_pair_type result);
      longint xl, xr, dl, dr, ml, mr, opp, fb, fl, fr, hl, hr, wl, wr;
      int unsigned d;
      int unsigned tap;
      xl = l_in;
      xr = r_in;
      d = (cfg_delay > DEPTH - 1) ? DEPTH - 1 : cfg_delay;
      tap = (line_head + DEPTH - d) % DEPTH;
      dl = left_line[tap];
      dr = right_line[tap];
      if (cfg_width != 0) begin
         opp = Q16_ONE - limit_gain(cfg_width);
         ml = dl + round_shift(opp * dr, 17);
         mr = dr + round_shift(opp * dl, 17);
      end else begin
         ml = round_shift(dl + dr, 1);
         mr = ml;
      end
      fb = limit_gain(cfg_feedback) * FEEDBACK_SCALE;
      fl = round_shift(ml * fb, 32);
      fr = round_shift(mr * fb, 32);
      if (cfg_ping_pong) begin
         left_line[line_head] = SBITS'(saturate(fr, SBITS));
         right_line[line_head] = SBITS'(saturate(xr + fl, SBITS));
      end else begin
         left_line[line_head] = SBITS'(saturate(xl + fl, SBITS));
         right_line[line_head] = SBITS'(saturate(xr + fr, SBITS));
      end
      filter_step(highpass_mem[0], ml, longint'(cfg_highpass), 1'b1, hl);
      filter_step(lowpass_mem[0], hl, longint'(cfg_lowpass), 1'b0, wl);
      filter_step(highpass_mem[1], mr, longint'(cfg_highpass), 1'b1, hr);
      filter_step(lowpass_mem[1], hr, longint'(cfg_lowpass), 1'b0, wr);
      result.left = SBITS'(saturate(xl + round_shift(wl * limit_gain(cfg_left_wet), 16), SBITS));
      result.right = SBITS'(saturate(xr + round_shift(wr * limit_gain(cfg_right_wet), 16), SBITS));
      line_head = (line_head + 1) % DEPTH;
   endtask

   task automatic send_pair(input logic signed [SBITS-1:0] left,
                            input logic signed [SBITS-1:0] right);
      stereo_pair_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_left_in <= left;
      req_right_in <= right;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_echo_mix(left, right, predicted);
      expected_pairs.push_back(predicted);
      @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_DELAY:     cfg_delay = value;
         CSR_FEEDBACK:  cfg_feedback = value;
         CSR_WIDTH:     cfg_width = value;
         CSR_PING_PONG: cfg_ping_pong = value[0];
         CSR_LEFT_WET:  cfg_left_wet = value;
         CSR_RIGHT_WET: cfg_right_wet = value;
         CSR_HIGHPASS:  cfg_highpass = value[15:0];
         CSR_LOWPASS:   cfg_lowpass = value[15:0];
         default:       ;
      endcase
      @(negedge clock);
   endtask

   task automatic apply_settings(input logic [16:0] delay, input logic [16:0] feedback,
                                 input logic [16:0] width, input logic [16:0] ping_pong,
                                 input logic [16:0] left_wet, input logic [16:0] right_wet,
                                 input logic [16:0] highpass, input logic [16:0] lowpass);
      write_reg(CSR_DELAY, delay);
      write_reg(CSR_FEEDBACK, feedback);
      write_reg(CSR_WIDTH, width);
      write_reg(CSR_PING_PONG, ping_pong);
      write_reg(CSR_LEFT_WET, left_wet);
      write_reg(CSR_RIGHT_WET, right_wet);
      write_reg(CSR_HIGHPASS, highpass);
      write_reg(CSR_LOWPASS, lowpass);
      csr_valid <= 1'b0;
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (expected_pairs.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   function automatic logic signed [SBITS-1:0] extreme_sample(input int k);
      case (k % 4)
         0:       return {1'b0, {(SBITS - 1){1'b1}}};
         1:       return {1'b1, {(SBITS - 1){1'b0}}};
         2:       return '0;
         default: return '1;
      endcase
   endfunction

   function automatic logic signed [SBITS-1:0] random_sample();
      case ($urandom_range(7))
         0:       return extreme_sample($urandom_range(3));
         1:       return SBITS'($signed($urandom_range(511)) - 256);
         default: return SBITS'($urandom);
      endcase
   endfunction

   function automatic logic [16:0] pick_gain();
      case ($urandom_range(5))
         0:       return 17'd0;
         1:       return 17'd65536;
         2:       return 17'($urandom_range(131071, 65537));
         default: return 17'($urandom_range(65536));
      endcase
   endfunction

   function automatic logic [16:0] pick_coef();
      case ($urandom_range(4))
         0:       return 17'd0;
         1:       return 17'd65535;
         default: return 17'($urandom_range(131071));
      endcase
   endfunction

   function automatic logic [16:0] pick_delay();
      case ($urandom_range(7))
         0:       return 17'd0;
         1:       return LONGEST_DELAY;
         2:       return 17'($urandom_range(131071));
         3:       return 17'($urandom_range(16, 1));
         default: return 17'($urandom_range(48, 1));
      endcase
   endfunction

   task automatic test_reset_defaults();
      for (int i = 0; i < 4; i++) begin
         send_pair(extreme_sample(i), extreme_sample(i + 1));
      end
   endtask

   task automatic test_extremes();
      drain_pipeline();
      apply_settings(17'd2, 17'd65536, 17'd0, 17'd0, 17'd65536, 17'd65536, 17'd0, 17'd65535);
      for (int i = 0; i < 8; i++) begin
         send_pair(extreme_sample(i), extreme_sample(i + i / 4 + 1));
      end
      drain_pipeline();
      apply_settings(17'd1, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF,
                     17'h1FFFF, 17'h10000);
      for (int i = 0; i < 8; i++) begin
         send_pair(extreme_sample(i + 2), extreme_sample(i + i / 4));
      end
   endtask

   task automatic test_random_settings(input int groups, input int items_per_group);
      for (int g = 0; g < groups; g++) begin
         drain_pipeline();
         apply_settings(pick_delay(), pick_gain(), pick_gain(), 17'($urandom), pick_gain(),
                        pick_gain(), pick_coef(), pick_coef());
         repeat (items_per_group) send_pair(random_sample(), random_sample());
      end
   endtask

   task automatic test_delay_limits();
      drain_pipeline();
      apply_settings(LONGEST_DELAY, pick_gain(), pick_gain(), 17'($urandom), 17'd65536,
                     17'd65536, 17'd0, 17'd65535);
      repeat (48) send_pair(random_sample(), random_sample());
      drain_pipeline();
      apply_settings(17'd0, pick_gain(), pick_gain(), 17'($urandom), 17'd65536,
                     17'd65536, 17'd0, 17'd65535);
      repeat (16) send_pair(random_sample(), random_sample());
   endtask

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      stereo_pair_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pairs.size() == 0) begin
            $error("rsp item arrived with no expected pair waiting");
            mismatches++;
         end else begin
            want = expected_pairs.pop_front();
            if (rsp_left_out !== want.left) begin
               $error("left_out: expected %0d, actual %0d", want.left, rsp_left_out);
               mismatches++;
            end
            if (rsp_right_out !== want.right) begin
               $error("right_out: expected %0d, actual %0d", want.right, rsp_right_out);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("stereo_feedback_delay: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_left_in = '0;
      req_right_in = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      line_head = 0;
      highpass_mem = '{0, 0};
      lowpass_mem = '{0, 0};
      sender_idle_pct = 24;
      receiver_idle_pct = 86;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_extremes();
      test_random_settings(8, 36);
      sender_idle_pct = 86;
      receiver_idle_pct = 24;
      test_random_settings(8, 36);
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      test_random_settings(8, 36);
      test_delay_limits();

      drain_pipeline();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("stereo_feedback_delay: match");
      end else begin
         $display("stereo_feedback_delay: mismatch");
      end
      $finish;
   end

endmodule

[files.f]
src/sfd_pkg.sv
src/sfd_lane.sv
src/stereo_feedback_delay.sv
verif/tb.sv
